FILE: hdl/vrrm_pkg.sv
// Shared types and constants of the variable-length record ring manager.
// Used by vrrm_ram, variable_record_ring_manager_top, record_ring_checker and tb_top; depends on nothing.
package vrrm_pkg;

    // Default number of header slots in the ring (one more is kept for the marker).
    localparam int RING_WORDS_DEF = 4096;

    localparam int MODE_W  = 3;
    localparam int BYTES_W = 14;
    localparam int LEN_W   = 13;
    localparam int OFF_W   = 13;
    localparam int CAP_W   = 13;
    localparam int STAT_W  = 2;

    // Largest capacity the register can express.
    localparam int CAP_REG_MAX = 8191;

    // Header word plus rounding to whole words: (bytes + 4 + 3) / 4.
    localparam int ROUND_ADD = 3;
    localparam int HDR_BYTES = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEFER    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PUBLISH  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESERVE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTES_W-1:0] payload_bytes;
    } vrrm_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   payload_offset;
        logic [BYTES_W-1:0] record_payload_bytes;
    } vrrm_out_t;

endpackage

FILE: hdl/vrrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on vrrm_pkg for its default sizes.
module vrrm_ram #(
    parameter int WIDTH = vrrm_pkg::LEN_W,
    parameter int DEPTH = vrrm_pkg::RING_WORDS_DEF + 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // The read data holds until the next read is issued.
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/variable_record_ring_manager_top.sv
// Top level of the variable-length record ring manager.
// Depends on vrrm_pkg and vrrm_ram.
//
// This block keeps the bookkeeping of a ring of 32-bit words that holds
// length-prefixed records: every record takes one header word with its length
// in words, followed by its payload rounded up to whole words. Only the
// headers are stored here (in one synchronous RAM with RING_WORDS+1 entries);
// the block hands out word offsets and never touches payload data. Each input
// word carries a mode (read, commit, deferred write, publish, reserve,
// complete reservation) and a payload length; each one gives exactly one
// result word with a status, a payload offset and, for reads, the rounded
// payload length. Items are worked on one at a time. A write goes from
// acceptance through ST_WR1 to the output register; a commit or deferred
// write that wraps past the end of the ring writes a zero marker in ST_WR1
// and its header at offset 0 in ST_WR2 on the single RAM write port before
// the next item is taken. A read goes through ST_RD1, and through ST_RD2 too
// when it meets a wrap marker, because the header RAM read is registered and
// the marker forces a second read at offset 0. A result waits in an output
// register, so the next item is accepted while it is still unclaimed; an
// item that finishes while the previous result is still waiting holds until
// that register is free. The header RAM has no reset and needs no clearing
// pass: a header is only used after it has been written. The capacity
// register may only be written while no item is in flight.
module variable_record_ring_manager_top #(
    parameter int RING_WORDS = vrrm_pkg::RING_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vrrm_pkg::vrrm_in_t                s_data,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output vrrm_pkg::vrrm_out_t               m_data,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vrrm_pkg::PADDR_W-1:0]      paddr,
    input  logic [vrrm_pkg::PDATA_W-1:0]      pwdata,
    output logic [vrrm_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int LEN_W   = vrrm_pkg::LEN_W;
    localparam int BYTES_W = vrrm_pkg::BYTES_W;
    localparam int OFF_W   = vrrm_pkg::OFF_W;
    localparam int CAP_W   = vrrm_pkg::CAP_W;

    // Header store depth and address width.
    localparam int DEPTH = RING_WORDS + 1;
    localparam int AW    = $clog2(DEPTH);
    // Largest effective capacity. A completed reservation may push the write
    // pointer up to twice that, so pointers are sized for it.
    localparam int CAP_MAX = (RING_WORDS < vrrm_pkg::CAP_REG_MAX) ? RING_WORDS
                                                                  : vrrm_pkg::CAP_REG_MAX;
    localparam int PW = $clog2(2 * CAP_MAX + 1);
    // Width for sums and compares of pointers and lengths.
    localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    // Width for the in-store check of a pointer.
    localparam int GW = (PW > AW) ? PW : AW;

    localparam logic [SW-1:0] CAP_LIM = SW'(CAP_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_WR1,
        ST_WR2
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           mode_reg, mode_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [CAP_W-1:0]     capacity_reg, capacity_next;

    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                 rd_lap_reg, rd_lap_next;
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic                 wr_lap_reg, wr_lap_next;
    logic [PW-1:0]        def_ptr_reg, def_ptr_next;
    logic                 def_lap_reg, def_lap_next;
    logic                 def_pend_reg, def_pend_next;
    logic [PW-1:0]        res_ptr_reg, res_ptr_next;
    logic                 res_lap_reg, res_lap_next;
    logic                 res_pend_reg, res_pend_next;
    logic [PW-1:0]        rel_ptr_reg, rel_ptr_next;
    logic                 rel_lap_reg, rel_lap_next;
    logic                 rel_pend_reg, rel_pend_next;

    logic                 m_valid_reg, m_valid_next;
    vrrm_pkg::vrrm_out_t  m_data_reg, m_data_next;
    logic                 rd_oob_reg, rd_oob_next;

    // Header RAM access.
    logic                 mem_we;
    logic [PW-1:0]        mem_wptr;
    logic [LEN_W-1:0]     mem_wdata;
    logic                 mem_re;
    logic [PW-1:0]        mem_rptr;
    logic [LEN_W-1:0]     mem_rdata;
    logic [LEN_W-1:0]     hdr_len;

    // Derived values.
    logic [SW-1:0]        cap_eff;
    logic [BYTES_W:0]     bytes_sum;
    logic [LEN_W-1:0]     leng;
    logic [SW-1:0]        leng_x;
    logic                 out_free;
    logic                 emit;
    vrrm_pkg::vrrm_out_t  res;

    // Read pointer after the pending release.
    logic [PW-1:0]        rpt_e;
    logic                 rpg_e;

    // Read check operands.
    logic [PW-1:0]        chk_rpt;
    logic                 chk_rpg;
    logic [SW-1:0]        chk_sum;
    logic                 chk_bad;
    logic [LEN_W-1:0]     len_m1;

    // Write operands.
    logic                 wr_err;
    logic [PW-1:0]        w_pt;
    logic                 w_pg;
    logic [SW-1:0]        w_sum;
    logic                 w_wrap;
    logic [PW-1:0]        n_pt;
    logic                 n_pg;
    logic [PW-1:0]        n_end;

    function automatic logic in_store(input logic [PW-1:0] p);
        return GW'(p) <= GW'(RING_WORDS);
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [PW-1:0] p);
        logic [GW-1:0] t;
        t = GW'(p);
        return t[AW-1:0];
    endfunction

    vrrm_ram #(
        .WIDTH (LEN_W),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (mem_we && in_store(mem_wptr)),
        .waddr (store_addr(mem_wptr)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (store_addr(mem_rptr)),
        .rdata (mem_rdata)
    );

    // A header slot beyond the store reads as zero.
    assign hdr_len = rd_oob_reg ? '0 : mem_rdata;

    assign cap_eff   = (SW'(capacity_reg) > CAP_LIM) ? CAP_LIM : SW'(capacity_reg);
    assign bytes_sum = {1'b0, bytes_reg}
                     + (BYTES_W + 1)'(vrrm_pkg::HDR_BYTES + vrrm_pkg::ROUND_ADD);
    assign leng      = bytes_sum[BYTES_W:2];
    assign leng_x    = SW'(leng);

    assign rpt_e = rel_pend_reg ? rel_ptr_reg : rd_ptr_reg;
    assign rpg_e = rel_pend_reg ? rel_lap_reg : rd_lap_reg;

    // The second read after a wrap marker restarts at offset 0 on the other lap.
    assign chk_rpt = (state_reg == ST_RD2) ? '0 : rpt_e;
    assign chk_rpg = (state_reg == ST_RD2) ? ~rpg_e : rpg_e;
    assign chk_sum = SW'(hdr_len) + SW'(chk_rpt);
    assign chk_bad = (hdr_len == '0) || (chk_sum > cap_eff)
                  || ((chk_sum > SW'(wr_ptr_reg)) && (chk_rpg == wr_lap_reg));
    assign len_m1  = hdr_len - LEN_W'(1);

    // A new record goes after the deferred one when that is still unpublished.
    assign wr_err = (mode_reg > vrrm_pkg::MODE_COMPLETE)
                 || ((mode_reg != vrrm_pkg::MODE_PUBLISH) && (bytes_reg == '0))
                 || (leng_x > cap_eff);
    assign w_pt   = def_pend_reg ? def_ptr_reg : wr_ptr_reg;
    assign w_pg   = def_pend_reg ? def_lap_reg : wr_lap_reg;
    assign w_sum  = SW'(w_pt) + leng_x;
    assign w_wrap = w_sum > cap_eff;
    assign n_pt   = w_wrap ? '0 : w_pt;
    assign n_pg   = w_wrap ? ~w_pg : w_pg;
    assign n_end  = PW'(SW'(n_pt) + leng_x);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        bytes_next    = bytes_reg;
        capacity_next = capacity_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_lap_next   = rd_lap_reg;
        wr_ptr_next   = wr_ptr_reg;
        wr_lap_next   = wr_lap_reg;
        def_ptr_next  = def_ptr_reg;
        def_lap_next  = def_lap_reg;
        def_pend_next = def_pend_reg;
        res_ptr_next  = res_ptr_reg;
        res_lap_next  = res_lap_reg;
        res_pend_next = res_pend_reg;
        rel_ptr_next  = rel_ptr_reg;
        rel_lap_next  = rel_lap_reg;
        rel_pend_next = rel_pend_reg;
        rd_oob_next   = rd_oob_reg;

        mem_we    = 1'b0;
        mem_wptr  = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_rptr  = rpt_e;

        emit = 1'b0;
        res  = '0;

        if (psel && penable && pwrite) begin
            capacity_next = pwdata[CAP_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    bytes_next = s_data.payload_bytes;
                    if (s_data.mode == vrrm_pkg::MODE_READ) begin
                        // Fetch the header under the released read pointer.
                        mem_re      = 1'b1;
                        mem_rptr    = rpt_e;
                        rd_oob_next = !in_store(rpt_e);
                        state_next  = ST_RD1;
                    end else begin
                        state_next = ST_WR1;
                    end
                end
            end

            ST_RD1, ST_RD2: begin
                if ((state_reg == ST_RD1) && !((rpg_e == wr_lap_reg)
                        && (SW'(rpt_e) >= SW'(wr_ptr_reg))) && (hdr_len == '0)
                        && !((~rpg_e == wr_lap_reg) && (wr_ptr_reg == '0))) begin
                    // Wrap marker: read the header at offset 0.
                    mem_re      = 1'b1;
                    mem_rptr    = '0;
                    rd_oob_next = 1'b0;
                    state_next  = ST_RD2;
                end else if (out_free) begin
                    emit          = 1'b1;
                    state_next    = ST_IDLE;
                    // The previous read's record is released in every outcome.
                    rd_ptr_next   = rpt_e;
                    rd_lap_next   = rpg_e;
                    rel_pend_next = 1'b0;
                    priority if ((state_reg == ST_RD1) && (rpg_e == wr_lap_reg)
                                 && (SW'(rpt_e) >= SW'(wr_ptr_reg))) begin
                        res.status = vrrm_pkg::STAT_EMPTY;
                    end else if ((state_reg == ST_RD1) && (hdr_len == '0)) begin
                        // Marker seen, and the ring is empty past it.
                        res.status = vrrm_pkg::STAT_EMPTY;
                    end else if (chk_bad) begin
                        res.status = vrrm_pkg::STAT_ERROR;
                    end else begin
                        res.status               = vrrm_pkg::STAT_DONE;
                        res.payload_offset       = OFF_W'(SW'(chk_rpt) + SW'(1));
                        res.record_payload_bytes = {len_m1[BYTES_W-3:0], 2'b00};
                        rel_ptr_next             = PW'(chk_sum);
                        rel_lap_next             = chk_rpg;
                        rel_pend_next            = 1'b1;
                    end
                end
            end

            ST_WR1: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    priority if (wr_err) begin
                        res.status = vrrm_pkg::STAT_ERROR;
                    end else if (res_pend_reg) begin
                        if (mode_reg != vrrm_pkg::MODE_COMPLETE) begin
                            res.status = vrrm_pkg::STAT_ERROR;
                        end else begin
                            // Header goes at the reserved slot with the length given now.
                            mem_we        = 1'b1;
                            mem_wptr      = res_ptr_reg;
                            mem_wdata     = leng;
                            wr_ptr_next   = PW'(SW'(res_ptr_reg) + leng_x);
                            wr_lap_next   = res_lap_reg;
                            res_pend_next = 1'b0;
                            res.status    = vrrm_pkg::STAT_DONE;
                        end
                    end else if (mode_reg == vrrm_pkg::MODE_COMPLETE) begin
                        res.status = vrrm_pkg::STAT_ERROR;
                    end else if (def_pend_reg && (mode_reg == vrrm_pkg::MODE_RESERVE)) begin
                        res.status = vrrm_pkg::STAT_ERROR;
                    end else begin
                        // Commit and publish first make a deferred record visible.
                        if (def_pend_reg && ((mode_reg == vrrm_pkg::MODE_COMMIT)
                                || (mode_reg == vrrm_pkg::MODE_PUBLISH))) begin
                            wr_ptr_next   = def_ptr_reg;
                            wr_lap_next   = def_lap_reg;
                            def_pend_next = 1'b0;
                        end
                        priority if (mode_reg == vrrm_pkg::MODE_PUBLISH) begin
                            res.status = vrrm_pkg::STAT_DONE;
                        end else if ((w_pg != rd_lap_reg) && (w_sum > SW'(rd_ptr_reg))) begin
                            res.status = vrrm_pkg::STAT_EMPTY;
                        end else if (w_wrap && (~w_pg != rd_lap_reg)
                                     && (leng_x > SW'(rd_ptr_reg))) begin
                            res.status = vrrm_pkg::STAT_EMPTY;
                        end else begin
                            res.status = vrrm_pkg::STAT_DONE;
                            if (w_wrap) begin
                                // Zero marker at the old write offset.
                                mem_we    = 1'b1;
                                mem_wptr  = w_pt;
                                mem_wdata = '0;
                            end
                            if (mode_reg == vrrm_pkg::MODE_RESERVE) begin
                                res_pend_next      = 1'b1;
                                res_ptr_next       = n_pt;
                                res_lap_next       = n_pg;
                                res.payload_offset = OFF_W'(SW'(n_pt) + SW'(1));
                            end else begin
                                if (w_wrap) begin
                                    state_next = ST_WR2;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_wptr  = w_pt;
                                    mem_wdata = leng;
                                end
                                if (mode_reg == vrrm_pkg::MODE_COMMIT) begin
                                    wr_ptr_next = n_end;
                                    wr_lap_next = n_pg;
                                end else begin
                                    def_ptr_next       = n_end;
                                    def_lap_next       = n_pg;
                                    def_pend_next      = 1'b1;
                                    res.payload_offset = OFF_W'(SW'(n_pt) + SW'(1));
                                end
                            end
                        end
                    end
                end
            end

            ST_WR2: begin
                // Header of a wrapped record at offset 0.
                mem_we     = 1'b1;
                mem_wptr   = '0;
                mem_wdata  = leng;
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            capacity_reg <= vrrm_pkg::CAP_RESET;
            rd_ptr_reg   <= '0;
            rd_lap_reg   <= 1'b0;
            wr_ptr_reg   <= '0;
            wr_lap_reg   <= 1'b0;
            def_ptr_reg  <= '0;
            def_lap_reg  <= 1'b0;
            def_pend_reg <= 1'b0;
            res_ptr_reg  <= '0;
            res_lap_reg  <= 1'b0;
            res_pend_reg <= 1'b0;
            rel_ptr_reg  <= '0;
            rel_lap_reg  <= 1'b0;
            rel_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_lap_reg   <= rd_lap_next;
            wr_ptr_reg   <= wr_ptr_next;
            wr_lap_reg   <= wr_lap_next;
            def_ptr_reg  <= def_ptr_next;
            def_lap_reg  <= def_lap_next;
            def_pend_reg <= def_pend_next;
            res_ptr_reg  <= res_ptr_next;
            res_lap_reg  <= res_lap_next;
            res_pend_reg <= res_pend_next;
            rel_ptr_reg  <= rel_ptr_next;
            rel_lap_reg  <= rel_lap_next;
            rel_pend_reg <= rel_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg   <= mode_next;
        bytes_reg  <= bytes_next;
        rd_oob_reg <= rd_oob_next;
        m_data_reg <= m_data_next;
    end

    // New items are taken only between items; the output register decouples
    // the result channel.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Every address maps onto the capacity register.
    assign prdata = {{(vrrm_pkg::PDATA_W - CAP_W){1'b0}}, capacity_reg};
    assign pready = 1'b1;

`ifndef SYNTHESIS
    // A reservation and a deferred record are never outstanding together.
    a_pend_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_pend_reg && def_pend_reg))
        else $error("reservation and deferred record both pending");

    // Reads never write the header store.
    a_read_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD1 || state_reg == ST_RD2) |-> !mem_we)
        else $error("header write during a read");

    // The second header write only follows a wrapping write.
    a_wr2_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR2) |-> ($past(state_reg) == ST_WR1))
        else $error("wrapped header write without a preceding write");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result register overwritten");
`endif

endmodule

FILE: sim/record_ring_checker.sv
`timescale 1ns / 100ps
// Checker for the variable-length record ring manager: it watches the request,
// result and configuration ports, predicts every result and compares it.
// Depends on vrrm_pkg for the word types, modes and status codes.
module record_ring_checker #(
    parameter int                            RING_WORDS = vrrm_pkg::RING_WORDS_DEF,
    parameter logic [vrrm_pkg::PADDR_W-1:0]  CAP_ADDR   = '0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  vrrm_pkg::vrrm_in_t           s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  vrrm_pkg::vrrm_out_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [vrrm_pkg::PADDR_W-1:0] paddr,
    input  logic [vrrm_pkg::PDATA_W-1:0] pwdata,
    output int                           mismatches,
    output int                           replies_due,
    output logic                         ring_drained
);
    import vrrm_pkg::*;

    int unsigned cap_words;
    int unsigned hdr_mem [0:RING_WORDS];
    int unsigned rd_ptr, rd_lap, wr_ptr, wr_lap;
    int unsigned dfr_ptr, dfr_lap, rsv_ptr, rsv_lap, rel_ptr, rel_lap;
    bit          dfr_busy, rsv_busy, rel_busy;
    vrrm_out_t   ring_replies_q [$];

    function automatic int unsigned header_at(input int unsigned idx);
        return (idx <= RING_WORDS) ? hdr_mem[idx] : 0;
    endfunction

    task automatic put_header(input int unsigned idx, input int unsigned len);
        if (idx <= RING_WORDS) begin
            hdr_mem[idx] = len;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic predict_ring_reply(input vrrm_in_t req, output vrrm_out_t res);
        int unsigned cap, leng, nbytes, rpt, rpg, wpt, wpg, start;
        cap    = (cap_words > RING_WORDS) ? RING_WORDS : cap_words;
        nbytes = req.payload_bytes;
        res    = '0;
        res.status = STAT_DONE;

        if (req.mode == MODE_READ) begin
            // The record handed out by the previous read is released first.
            if (rel_busy) begin
                rd_ptr   = rel_ptr;
                rd_lap   = rel_lap;
                rel_busy = 0;
            end
            rpt = rd_ptr;
            rpg = rd_lap;
            if (rpg == wr_lap && rpt >= wr_ptr) begin
                res.status = STAT_EMPTY;
                return;
            end
            leng = header_at(rpt);
            if (leng == 0) begin
                rpt  = 0;
                rpg ^= 1;
                leng = header_at(0);
                if (rpg == wr_lap && rpt >= wr_ptr) begin
                    res.status = STAT_EMPTY;
                    return;
                end
            end
            if (leng < 1 || leng + rpt > cap || (leng + rpt > wr_ptr && rpg == wr_lap)) begin
                res.status = STAT_ERROR;
                return;
            end
            rel_ptr  = rpt + leng;
            rel_lap  = rpg;
            rel_busy = 1;
            res.payload_offset       = OFF_W'(rpt + 1);
            res.record_payload_bytes = BYTES_W'((leng - 1) * HDR_BYTES);
            return;
        end

        leng = (nbytes + HDR_BYTES + ROUND_ADD) >> 2;
        if (req.mode > MODE_COMPLETE || (req.mode != MODE_PUBLISH && nbytes == 0)
                || leng > cap) begin
            res.status = STAT_ERROR;
            return;
        end

        if (rsv_busy) begin
            if (req.mode != MODE_COMPLETE) begin
                res.status = STAT_ERROR;
                return;
            end
            rsv_busy = 0;
            wpt = rsv_ptr;
            wpg = rsv_lap;
        end else begin
            if (req.mode == MODE_COMPLETE) begin
                res.status = STAT_ERROR;
                return;
            end
            if (dfr_busy) begin
                if (req.mode == MODE_COMMIT || req.mode == MODE_PUBLISH) begin
                    wr_ptr   = dfr_ptr;
                    wr_lap   = dfr_lap;
                    dfr_busy = 0;
                end else if (req.mode == MODE_RESERVE) begin
                    res.status = STAT_ERROR;
                    return;
                end
            end
            if (req.mode == MODE_PUBLISH) begin
                return;
            end
            rpt = rd_ptr;
            rpg = rd_lap;
            wpt = dfr_busy ? dfr_ptr : wr_ptr;
            wpg = dfr_busy ? dfr_lap : wr_lap;
            if (rpg != wpg && wpt + leng > rpt) begin
                res.status = STAT_EMPTY;
                return;
            end
            if (wpt + leng > cap) begin
                // No room before the end: marker at the old offset, restart at 0.
                start = wpt;
                wpt   = 0;
                wpg  ^= 1;
                if (rpg != wpg && leng > rpt) begin
                    res.status = STAT_EMPTY;
                    return;
                end
                put_header(start, 0);
            end
            if (req.mode == MODE_RESERVE) begin
                rsv_busy = 1;
                rsv_ptr  = wpt;
                rsv_lap  = wpg;
                res.payload_offset = OFF_W'(wpt + 1);
                return;
            end
        end

        start = wpt;
        put_header(wpt, leng);
        wpt = wpt + leng;
        if (req.mode == MODE_COMMIT || req.mode == MODE_COMPLETE) begin
            wr_ptr = wpt;
            wr_lap = wpg;
            return;
        end
        dfr_ptr  = wpt;
        dfr_lap  = wpg;
        dfr_busy = 1;
        res.payload_offset = OFF_W'(start + 1);
    endtask

    always @(posedge aclk) begin : watch
        vrrm_out_t due;
        if (!aresetn) begin
            cap_words = CAP_RESET;
            rd_ptr = 0; rd_lap = 0; wr_ptr = 0; wr_lap = 0;
            dfr_ptr = 0; dfr_lap = 0; dfr_busy = 0;
            rsv_ptr = 0; rsv_lap = 0; rsv_busy = 0;
            rel_ptr = 0; rel_lap = 0; rel_busy = 0;
            ring_replies_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
                cap_words = pwdata[CAP_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (ring_replies_q.size() == 0) begin
                    note_failure($sformatf("unexpected result word status %0d offset %0d bytes %0d",
                        m_data.status, m_data.payload_offset, m_data.record_payload_bytes));
                end else begin
                    due = ring_replies_q.pop_front();
                    if (m_data !== due) begin
                        note_failure($sformatf(
                            "result mismatch: expected status %0d offset %0d bytes %0d, got %0d %0d %0d",
                            due.status, due.payload_offset, due.record_payload_bytes,
                            m_data.status, m_data.payload_offset, m_data.record_payload_bytes));
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_ring_reply(s_data, due);
                ring_replies_q.push_back(due);
            end
        end
        replies_due  = ring_replies_q.size();
        ring_drained = ((rel_busy ? rel_ptr : rd_ptr) == wr_ptr)
                    && ((rel_busy ? rel_lap : rd_lap) == wr_lap) && !dfr_busy && !rsv_busy;
    end

    initial begin
        mismatches   = 0;
        replies_due  = 0;
        ring_drained = 1'b1;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the record ring manager testbench: clock, reset, stimulus and verdict.
// Depends on vrrm_pkg, variable_record_ring_manager_top and record_ring_checker.
module tb_top;
    import vrrm_pkg::*;

    // The only register, capacity_words, is register 0 at byte address 0.
    localparam logic [PADDR_W-1:0] CAP_ADDR = '0;
    localparam int STALL_MAX = 12;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    vrrm_in_t            s_data;
    logic                m_valid;
    logic                m_ready;
    vrrm_out_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int   mismatches;
    int   replies_due;
    logic ring_drained;
    int   cfg_errors;
    int   words_sent;
    int   stall_left;
    bit   quiet;

    // 12 ns clock period.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    variable_record_ring_manager_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    record_ring_checker #(
        .CAP_ADDR (CAP_ADDR)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .replies_due  (replies_due),
        .ring_drained (ring_drained)
    );

    // The result side stalls in random bursts. Once the quiet flag is
    // set for the last part of the run, ready stays high all the time.
    always @(negedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, STALL_MAX) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one request word and returns at the falling edge after it has been
    // taken. Valid is left high, so back-to-back words see no bubble unless a
    // random gap is chosen; a gap lowers valid in this step and raises it again
    // only at a later falling edge.
    task automatic send_word(input logic [MODE_W-1:0] mode, input int unsigned nbytes);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{mode: mode, payload_bytes: BYTES_W'(nbytes)};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Drops valid and waits until every predicted result has been claimed.
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (replies_due == 0);
        @(negedge aclk);
    endtask

    // Writes the capacity register while the block is idle, then reads it back.
    task automatic set_capacity(input int unsigned words);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= PDATA_W'(words);
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[CAP_W-1:0] !== CAP_W'(words)) begin
            cfg_errors++;
            $display("%0t: capacity readback %0d, wrote %0d", $realtime,
                readback[CAP_W-1:0], words);
        end
    endtask

    // Picks a payload length whose record still fits the given capacity. Most
    // lengths are short so that many records share the ring; a few are huge.
    function automatic int unsigned fitting_bytes(input int unsigned cap);
        int unsigned most, pick;
        most = ((cap > RING_WORDS_DEF) ? RING_WORDS_DEF : cap) * 4 - HDR_BYTES;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return $urandom_range(1, (most < 64) ? most : 64);
        end else if (pick < 92) begin
            return $urandom_range(1, (most < 1024) ? most : 1024);
        end
        return $urandom_range(1, most);
    endfunction

    // Random traffic made mostly of well-formed sequences with random lengths:
    // commits, bursts of reads, deferred writes closed by a publish or a commit,
    // and reserve/complete pairs. The rest is noise over every mode and length.
    task automatic random_traffic(input int count, input int unsigned cap);
        int          stop_at;
        int unsigned nbytes, other;
        int          kind;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            kind   = $urandom_range(0, 99);
            nbytes = fitting_bytes(cap);
            if (kind < 28) begin
                send_word(MODE_COMMIT, nbytes);
            end else if (kind < 55) begin
                repeat ($urandom_range(1, 3)) send_word(MODE_READ, $urandom_range(0, 16383));
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 3)) send_word(MODE_DEFER, fitting_bytes(cap));
                if ($urandom_range(0, 3) != 0) begin
                    send_word(MODE_PUBLISH, $urandom_range(0, 8));
                end else begin
                    send_word(MODE_COMMIT, nbytes);
                end
            end else if (kind < 85) begin
                // The completion mostly repeats the reserved length, sometimes
                // a shorter or a longer one.
                send_word(MODE_RESERVE, nbytes);
                other = fitting_bytes(cap);
                case ($urandom_range(0, 9))
                    0, 1: send_word(MODE_COMPLETE, (other < nbytes) ? other : nbytes);
                    2:    send_word(MODE_COMPLETE, (other > nbytes) ? other : nbytes);
                    default: send_word(MODE_COMPLETE, nbytes);
                endcase
            end else begin
                send_word(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 16383));
            end
        end
    endtask

    // Closes any open reservation or deferred write and reads until the ring
    // is empty, so that a new capacity starts from a clean ring. A ring left
    // with unreadable headers gives up after a bounded number of reads.
    task automatic drain_ring();
        send_word(MODE_COMPLETE, 4);
        send_word(MODE_PUBLISH, 0);
        wait_idle();
        for (int i = 0; i < 3 && !ring_drained; i++) begin
            repeat (8) send_word(MODE_READ, 0);
            wait_idle();
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_errors = 0;
        words_sent = 0;
        stall_left = 0;
        quiet      = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at full capacity. The ring is traced by hand below:
        // offsets are in words, lengths include the header word.
        set_capacity(4096);
        send_word(MODE_READ, 0);               // empty ring
        send_word(3'd6, 100);                  // unused mode
        send_word(3'd7, 16383);                // unused mode, longest field value
        send_word(MODE_COMMIT, 0);             // zero payload on a write
        send_word(MODE_COMMIT, 16383);         // record longer than the capacity
        send_word(MODE_COMMIT, 1);             // two-word record at offset 0
        send_word(MODE_COMMIT, 16380);         // whole-ring record must wrap: full
        send_word(MODE_READ, 16383);           // returns the record at offset 0
        send_word(MODE_DEFER, 5);              // deferred record at offset 2
        send_word(MODE_READ, 0);               // deferred record not yet visible
        send_word(MODE_RESERVE, 4);            // reserve while a deferred write waits
        send_word(MODE_PUBLISH, 0);            // publish the deferred record
        send_word(MODE_PUBLISH, 16383);        // publish that is too long
        send_word(MODE_COMPLETE, 4);           // complete without a reservation
        send_word(MODE_READ, 0);               // published record
        send_word(MODE_RESERVE, 40);           // reservation at offset 5
        send_word(MODE_COMMIT, 4);             // write while a reservation waits
        send_word(MODE_COMPLETE, 48);          // complete with a longer length
        send_word(MODE_READ, 0);               // completed record
        send_word(MODE_READ, 0);               // releases it, ring empty
        send_word(MODE_COMMIT, 16000);         // long record up to offset 4019
        send_word(MODE_READ, 0);
        send_word(MODE_READ, 0);               // release, reader at 4019
        send_word(MODE_COMMIT, 400);           // wrap marker at 4019, record at 0
        send_word(MODE_READ, 0);               // reader follows the wrap marker
        wait_idle();

        random_traffic(140, 4096);
        drain_ring();

        // Smallest capacity: lengths are picked to fit, records wrap constantly.
        set_capacity(4);
        random_traffic(100, 4);
        drain_ring();

        // Largest register value, which behaves as the full ring.
        set_capacity(8191);
        random_traffic(150, 8191);
        wait_idle();

        // Shrinking with records still in the ring leaves headers past the
        // new capacity, which reads must report as errors.
        set_capacity(37);
        random_traffic(80, 37);
        drain_ring();

        set_capacity(200);
        random_traffic(100, 200);
        drain_ring();

        // Last part at full capacity with no idling on either side.
        set_capacity(4096);
        quiet = 1'b1;
        random_traffic(120, 4096);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && cfg_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
